@@ rtl/core/bis_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package bis_pkg;

    // Field and register widths
    localparam int CFG_W     = 10;
    localparam int COORD_W   = 9;
    localparam int COLOR_W   = 24;
    localparam int CH_W      = 8;
    localparam int NUM_CH    = 3;
    localparam int CFG_IDX_W = 2;
    // Width wide enough to compare a size register against any size limit
    localparam int CMP_W     = 14;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 2'd3;

    // Configuration reset values
    localparam logic [CFG_W-1:0] RST_SRC_WIDTH  = 10'd512;
    localparam logic [CFG_W-1:0] RST_SRC_HEIGHT = 10'd512;
    localparam logic [CFG_W-1:0] RST_DST_WIDTH  = 10'd510;
    localparam logic [CFG_W-1:0] RST_DST_HEIGHT = 10'd510;

    // Item opcodes
    localparam logic OP_WRITE   = 1'b0;
    localparam logic OP_COMPUTE = 1'b1;

    typedef struct packed {
        logic               opcode;
        logic [COORD_W-1:0] src_x;
        logic [COORD_W-1:0] src_y;
        logic [COLOR_W-1:0] pixel_color;
        logic [COORD_W-1:0] dst_x;
        logic [COORD_W-1:0] dst_y;
    } t_item;

    typedef struct packed {
        logic [COORD_W-1:0] result_x;
        logic [COORD_W-1:0] result_y;
        logic [COLOR_W-1:0] result_color;
    } t_result;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_MAP,
        ST_READ,
        ST_DRAIN
    } t_state;

endpackage

`default_nettype wire

@@ rtl/core/bilinear_image_scaler_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Write item: stored at the accepting edge; one write per clock while busy is low.
// Compute item: divide (ST_DIV), map (ST_MAP), four neighbor reads (ST_READ) and drain
// (ST_DRAIN) and a registered result strobe; busy holds off items until the strobe cycle.
// The pace is set by the bit-serial mapping divider (FRAC_BITS+19 steps) and the four
// neighbor reads through the single source memory port.
// Synchronous active-low reset restores the sizes and idles the sequencer, keeping the source
// memory; results are one-cycle strobes and the receiver cannot stall.

module bilinear_image_scaler_top #(
    parameter int MAX_SRC_WIDTH  = 512,
    parameter int MAX_SRC_HEIGHT = 512,
    parameter int MAX_DST_WIDTH  = 512,
    parameter int MAX_DST_HEIGHT = 512,
    parameter int FRAC_BITS      = 8
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 start,
    output logic                                busy,
    input  wire  bis_pkg::t_item                i_item,
    output logic                                o_result_strobe,
    output bis_pkg::t_result                    o_result,
    input  wire                                 i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire  [bis_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire  [bis_pkg::CFG_W-1:0]           i_cfg_data
);
    import bis_pkg::*;

    localparam int DEPTH  = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
    localparam int AW     = $clog2(DEPTH);
    localparam int NUM_W  = COORD_W + CFG_W;
    localparam int DIV_W  = NUM_W + FRAC_BITS;
    localparam int CNT_W  = $clog2(DIV_W + 1);
    localparam int ONE_W  = FRAC_BITS + 1;
    localparam int WGT_W  = 2 * FRAC_BITS + 1;
    localparam int ACC_W  = 2 * FRAC_BITS + CH_W;
    localparam int ADDR_PW = AW + CFG_W;

    // Saturate a size register into its legal range
    function automatic logic [CFG_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
                                                    input int lo, input int hi);
        logic [CMP_W-1:0] ve;
        ve = CMP_W'(v);
        if (ve < CMP_W'(lo)) begin
            return CFG_W'(lo);
        end else if (ve > CMP_W'(hi)) begin
            return CFG_W'(hi);
        end
        return v;
    endfunction

    // Row-major source address
    function automatic logic [AW-1:0] pix_addr(input logic [CFG_W-1:0] x,
                                               input logic [CFG_W-1:0] y);
        logic [ADDR_PW-1:0] p;
        p = ADDR_PW'(y) * ADDR_PW'(MAX_SRC_WIDTH) + ADDR_PW'(x);
        return p[AW-1:0];
    endfunction

    // One restoring division step: {quotient bit, new remainder}
    function automatic logic [CFG_W:0] div_step(input logic [CFG_W-1:0] rem,
                                                input logic bit_in,
                                                input logic [CFG_W-1:0] den);
        logic [CFG_W:0] sh;
        logic [CFG_W:0] diff;
        sh   = {rem, bit_in};
        diff = sh - {1'b0, den};
        if (sh >= {1'b0, den}) begin
            return {1'b1, diff[CFG_W-1:0]};
        end
        return {1'b0, sh[CFG_W-1:0]};
    endfunction

    // Configuration registers
    logic [CFG_W-1:0] r_src_w, r_src_h, r_dst_w, r_dst_h;

    // Sequencer
    t_state r_state, n_state;
    logic   w_accept, w_rd_en;

    // Divider
    logic [DIV_W-1:0] r_dvx, r_dvy, n_dvx, n_dvy;
    logic [CFG_W-1:0] r_remx, r_remy, n_remx, n_remy;
    logic [CFG_W-1:0] r_denx, r_deny;
    logic [CNT_W-1:0] r_cnt;
    logic [CFG_W:0]   w_stepx, w_stepy;

    // Mapped neighbors
    logic [CFG_W-1:0]     r_x1, r_x2, r_y1, r_y2;
    logic [FRAC_BITS-1:0] r_fx, r_fy;
    logic [CFG_W-1:0]     n_x1, n_x2, n_y1, n_y2;
    logic [FRAC_BITS-1:0] n_fx, n_fy;
    logic [COORD_W-1:0]   r_dx, r_dy;
    logic [1:0]           r_nb;

    // Blend datapath
    logic [ONE_W-1:0]   w_wa, w_wb;
    logic [2*ONE_W-1:0] w_wprod;
    logic [WGT_W-1:0]   r_wgt;
    logic [COLOR_W-1:0] r_rdata;
    logic [AW-1:0]      w_raddr;
    logic [ACC_W-1:0]   r_acc [NUM_CH];
    logic [ACC_W-1:0]   n_acc [NUM_CH];

    // Source memory
    logic [COLOR_W-1:0] r_mem [DEPTH];

    // Sizes after saturation
    logic [CFG_W-1:0] w_wm1, w_hm1, w_dwm1, w_dhm1;
    logic [NUM_W-1:0] w_numx, w_numy;

    always_comb begin
        w_wm1  = clamp_size(r_src_w, 1, MAX_SRC_WIDTH) - CFG_W'(1);
        w_hm1  = clamp_size(r_src_h, 1, MAX_SRC_HEIGHT) - CFG_W'(1);
        w_dwm1 = clamp_size(r_dst_w, 2, MAX_DST_WIDTH) - CFG_W'(1);
        w_dhm1 = clamp_size(r_dst_h, 2, MAX_DST_HEIGHT) - CFG_W'(1);
        w_numx = NUM_W'(i_item.dst_x) * NUM_W'(w_wm1);
        w_numy = NUM_W'(i_item.dst_y) * NUM_W'(w_hm1);
    end

    // Take configuration writes at any time
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w <= RST_SRC_WIDTH;
            r_src_h <= RST_SRC_HEIGHT;
            r_dst_w <= RST_DST_WIDTH;
            r_dst_h <= RST_DST_HEIGHT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_SRC_WIDTH:  r_src_w <= i_cfg_data;
                REG_SRC_HEIGHT: r_src_h <= i_cfg_data;
                REG_DST_WIDTH:  r_dst_w <= i_cfg_data;
                REG_DST_HEIGHT: r_dst_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (start && i_item.opcode == OP_COMPUTE) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (r_cnt == CNT_W'(1)) begin
                    n_state = ST_MAP;
                end
            end
            ST_MAP:  n_state = ST_READ;
            ST_READ: begin
                if (r_nb == 2'd3) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        busy    = (r_state != ST_IDLE);
        w_rd_en = (r_state == ST_READ);
    end

    assign w_accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Divider step for both axes
    always_comb begin
        w_stepx = div_step(r_remx, r_dvx[DIV_W-1], r_denx);
        w_stepy = div_step(r_remy, r_dvy[DIV_W-1], r_deny);
        n_dvx   = {r_dvx[DIV_W-2:0], w_stepx[CFG_W]};
        n_dvy   = {r_dvy[DIV_W-2:0], w_stepy[CFG_W]};
        n_remx  = w_stepx[CFG_W-1:0];
        n_remy  = w_stepy[CFG_W-1:0];
    end

    // Load the scaled coordinates, then shift quotient bits in
    always_ff @(posedge i_clk) begin
        if (w_accept && i_item.opcode == OP_COMPUTE) begin
            r_dvx  <= {w_numx, {FRAC_BITS{1'b0}}};
            r_dvy  <= {w_numy, {FRAC_BITS{1'b0}}};
            r_remx <= '0;
            r_remy <= '0;
            r_denx <= w_dwm1;
            r_deny <= w_dhm1;
            r_cnt  <= CNT_W'(DIV_W);
            r_dx   <= i_item.dst_x;
            r_dy   <= i_item.dst_y;
        end else if (r_state == ST_DIV) begin
            r_dvx  <= n_dvx;
            r_dvy  <= n_dvy;
            r_remx <= n_remx;
            r_remy <= n_remy;
            r_cnt  <= r_cnt - CNT_W'(1);
        end
    end

    // Clamp the integer parts and pick the right and lower neighbors
    always_comb begin
        if (r_dvx[DIV_W-1:FRAC_BITS] >= NUM_W'(w_wm1)) begin
            n_x1 = w_wm1;
            n_fx = '0;
        end else begin
            n_x1 = r_dvx[FRAC_BITS +: CFG_W];
            n_fx = r_dvx[FRAC_BITS-1:0];
        end
        if (r_dvy[DIV_W-1:FRAC_BITS] >= NUM_W'(w_hm1)) begin
            n_y1 = w_hm1;
            n_fy = '0;
        end else begin
            n_y1 = r_dvy[FRAC_BITS +: CFG_W];
            n_fy = r_dvy[FRAC_BITS-1:0];
        end
        n_x2 = (({1'b0, n_x1} + 1'b1) < {1'b0, w_wm1}) ? n_x1 + CFG_W'(1) : w_wm1;
        n_y2 = (({1'b0, n_y1} + 1'b1) < {1'b0, w_hm1}) ? n_y1 + CFG_W'(1) : w_hm1;
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_MAP) begin
            r_x1 <= n_x1;
            r_x2 <= n_x2;
            r_y1 <= n_y1;
            r_y2 <= n_y2;
            r_fx <= n_fx;
            r_fy <= n_fy;
            r_nb <= '0;
        end else if (r_state == ST_READ) begin
            r_nb <= r_nb + 2'd1;
        end
    end

    // Neighbor address and weight for the current read
    always_comb begin
        case (r_nb)
            2'd0:    w_raddr = pix_addr(r_x1, r_y1);
            2'd1:    w_raddr = pix_addr(r_x1, r_y2);
            2'd2:    w_raddr = pix_addr(r_x2, r_y1);
            2'd3:    w_raddr = pix_addr(r_x2, r_y2);
            default: w_raddr = '0;
        endcase
        w_wa    = r_nb[1] ? {1'b0, r_fx} : ({1'b1, {FRAC_BITS{1'b0}}} - {1'b0, r_fx});
        w_wb    = r_nb[0] ? {1'b0, r_fy} : ({1'b1, {FRAC_BITS{1'b0}}} - {1'b0, r_fy});
        w_wprod = (2*ONE_W)'(w_wa) * (2*ONE_W)'(w_wb);
    end

    // Hold the weight alongside the read data
    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_wgt <= w_wprod[WGT_W-1:0];
        end
    end

    // Source memory: writes from items, reads from the blend sequence
    always_ff @(posedge i_clk) begin
        if (w_accept && i_item.opcode == OP_WRITE &&
            CMP_W'(i_item.src_x) < CMP_W'(MAX_SRC_WIDTH) &&
            CMP_W'(i_item.src_y) < CMP_W'(MAX_SRC_HEIGHT)) begin
            r_mem[pix_addr(CFG_W'(i_item.src_x), CFG_W'(i_item.src_y))] <= i_item.pixel_color;
        end
        if (w_rd_en) begin
            r_rdata <= r_mem[w_raddr];
        end
    end

    // Weighted channel sums
    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            n_acc[c] = r_acc[c] + ACC_W'(r_wgt) * ACC_W'(r_rdata[c*CH_W +: CH_W]);
        end
    end

    // Accumulate one neighbor a cycle, drop the fraction on the last
    always_ff @(posedge i_clk) begin
        for (int c = 0; c < NUM_CH; c++) begin
            if (r_state == ST_MAP) begin
                r_acc[c] <= '0;
            end else if (r_state == ST_READ && r_nb != 2'd0) begin
                r_acc[c] <= n_acc[c];
            end
        end
        if (r_state == ST_DRAIN) begin
            o_result.result_x <= r_dx;
            o_result.result_y <= r_dy;
            for (int c = 0; c < NUM_CH; c++) begin
                o_result.result_color[c*CH_W +: CH_W] <= n_acc[c][ACC_W-1 -: CH_W];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_result_strobe <= 1'b0;
        end else begin
            o_result_strobe <= (r_state == ST_DRAIN);
        end
    end

    // Checks on the sequencer
    a_strobe_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> $past(r_state == ST_DRAIN))
        else $error("result strobe without a finished blend");

    a_compute_starts_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_item.opcode == OP_COMPUTE)
        |=> (r_state == ST_DIV && r_cnt == CNT_W'(DIV_W)))
        else $error("compute beat did not start the divider");

    a_write_stays_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_item.opcode == OP_WRITE) |=> (r_state == ST_IDLE))
        else $error("write beat left idle");

    a_map_to_first_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MAP) |=> (r_state == ST_READ && r_nb == 2'd0))
        else $error("read sequence did not start at first neighbor");

    a_four_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ && r_nb != 2'd3) |=> (r_state == ST_READ))
        else $error("read sequence cut short");

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import bis_pkg::*;

    localparam int MAX_W        = 512;
    localparam int MAX_H        = 512;
    localparam int MAX_DW       = 512;
    localparam int MAX_DH       = 512;
    localparam int FRAC         = 8;
    localparam int DRAIN_CYCLES = 45;
    localparam int PHASE_ITEMS  = 15;
    localparam int RANDOM_ITEMS = 500;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    t_item                i_item;
    logic                 o_result_strobe;
    t_result              o_result;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;

    bilinear_image_scaler_top uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_item          (i_item),
        .o_result_strobe (o_result_strobe),
        .o_result        (o_result),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // Model of the scaler: source image, size registers, pending pixels
    class scaler_scoreboard;
        bit [COLOR_W-1:0] image_mem [int];
        logic [CFG_W-1:0] src_w_reg, src_h_reg, dst_w_reg, dst_h_reg;
        t_result          pixel_q [$];
        int               failures;

        function new();
            src_w_reg = RST_SRC_WIDTH;
            src_h_reg = RST_SRC_HEIGHT;
            dst_w_reg = RST_DST_WIDTH;
            dst_h_reg = RST_DST_HEIGHT;
            failures  = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                REG_SRC_WIDTH:  src_w_reg = val;
                REG_SRC_HEIGHT: src_h_reg = val;
                REG_DST_WIDTH:  dst_w_reg = val;
                REG_DST_HEIGHT: dst_h_reg = val;
                default: ;
            endcase
        endfunction

        function int unsigned sat(int unsigned v, int unsigned lo, int unsigned hi);
            if (v < lo) return lo;
            if (v > hi) return hi;
            return v;
        endfunction

        function void dst_bounds(output int unsigned dw, output int unsigned dh);
            dw = sat(dst_w_reg, 2, MAX_DW);
            dh = sat(dst_h_reg, 2, MAX_DH);
        endfunction

        function bit written(int unsigned x, int unsigned y);
            return image_mem.exists(y * MAX_W + x);
        endfunction

        function bit [COLOR_W-1:0] pixel(int unsigned x, int unsigned y);
            if (!written(x, y)) return '0;
            return image_mem[y * MAX_W + x];
        endfunction

        // Map one destination coordinate onto the source axis
        function void map_axis(input int unsigned d, input int unsigned s,
                               input int unsigned n, output int unsigned ip,
                               output int unsigned fr);
            int unsigned num, den;
            num = d * (s - 1);
            den = n - 1;
            ip  = num / den;
            fr  = ((num % den) << FRAC) / den;
            if (ip >= s - 1) begin
                ip = s - 1;
                fr = 0;
            end
        endfunction

        // Find the four neighbors and the fractions for a destination pixel
        function void locate(input int unsigned dx, input int unsigned dy,
                             output int unsigned x1, output int unsigned x2,
                             output int unsigned y1, output int unsigned y2,
                             output int unsigned fx, output int unsigned fy);
            int unsigned w, h, dw, dh;
            w = sat(src_w_reg, 1, MAX_W);
            h = sat(src_h_reg, 1, MAX_H);
            dst_bounds(dw, dh);
            map_axis(dx, w, dw, x1, fx);
            map_axis(dy, h, dh, y1, fy);
            x2 = (x1 + 1 < w - 1) ? x1 + 1 : w - 1;
            y2 = (y1 + 1 < h - 1) ? y1 + 1 : h - 1;
        endfunction

        // Store a source pixel or queue the blended destination pixel
        function void note_item(t_item it);
            int unsigned x1, x2, y1, y2, fx, fy;
            int unsigned w11, w12, w21, w22, acc, one;
            bit [COLOR_W-1:0] c11, c12, c21, c22;
            t_result px;
            if (it.opcode == OP_WRITE) begin
                image_mem[it.src_y * MAX_W + it.src_x] = it.pixel_color;
                return;
            end
            locate(it.dst_x, it.dst_y, x1, x2, y1, y2, fx, fy);
            c11 = pixel(x1, y1);
            c12 = pixel(x1, y2);
            c21 = pixel(x2, y1);
            c22 = pixel(x2, y2);
            one = 1 << FRAC;
            w11 = (one - fx) * (one - fy);
            w12 = (one - fx) * fy;
            w21 = fx * (one - fy);
            w22 = fx * fy;
            px.result_x = it.dst_x;
            px.result_y = it.dst_y;
            for (int ch = 0; ch < NUM_CH; ch++) begin
                acc = w11 * c11[ch*CH_W +: CH_W] + w12 * c12[ch*CH_W +: CH_W]
                    + w21 * c21[ch*CH_W +: CH_W] + w22 * c22[ch*CH_W +: CH_W];
                px.result_color[ch*CH_W +: CH_W] = CH_W'(acc >> (2 * FRAC));
            end
            pixel_q = {pixel_q, px};
        endfunction

        // Compare one result beat against the oldest queued pixel
        function void check_result(t_result got);
            t_result want;
            if (pixel_q.size() == 0) begin
                if (failures < 10)
                    $display("unexpected result x=%0d y=%0d color=%06h",
                             got.result_x, got.result_y, got.result_color);
                failures++;
                return;
            end
            want = pixel_q.pop_front();
            if (got.result_x !== want.result_x || got.result_y !== want.result_y ||
                got.result_color !== want.result_color) begin
                if (failures < 10)
                    $display("mismatch: want x=%0d y=%0d c=%06h got x=%0d y=%0d c=%06h",
                             want.result_x, want.result_y, want.result_color,
                             got.result_x, got.result_y, got.result_color);
                failures++;
            end
        endfunction

        function int pending();
            return pixel_q.size();
        endfunction
    endclass

    scaler_scoreboard sb = new();
    bit               idle_on = 1'b1;
    int unsigned      items_sent = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Generous limit far above the slowest legal run
    initial begin
        #10_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

    // Check every result beat
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_strobe)
            sb.check_result(o_result);
    end

    function automatic bit [COLOR_W-1:0] rand_color();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    // Present one item, hold it until accepted, note it
    task automatic send_item(input t_item it);
        @(negedge i_clk);
        while (idle_on && $urandom_range(99) < 23) begin
            start = 1'b0;
            if ($urandom_range(9) == 0)
                repeat ($urandom_range(40, 2)) @(negedge i_clk);
            else
                @(negedge i_clk);
        end
        start  = 1'b1;
        i_item = it;
        do @(posedge i_clk); while (busy);
        sb.note_item(it);
        items_sent++;
    endtask

    task automatic write_pixel(input int unsigned x, input int unsigned y,
                               input bit [COLOR_W-1:0] c);
        t_item it;
        it             = $urandom;
        it.opcode      = OP_WRITE;
        it.src_x       = x;
        it.src_y       = y;
        it.pixel_color = c;
        it.dst_x       = $urandom;
        it.dst_y       = $urandom;
        send_item(it);
    endtask

    // Write any missing neighbor, optionally refresh some, then compute
    task automatic compute_at(input int unsigned dx, input int unsigned dy,
                              input bit refresh);
        int unsigned x1, x2, y1, y2, fx, fy;
        int unsigned nx [4];
        int unsigned ny [4];
        t_item it;
        sb.locate(dx, dy, x1, x2, y1, y2, fx, fy);
        nx = '{x1, x1, x2, x2};
        ny = '{y1, y2, y1, y2};
        for (int k = 0; k < 4; k++) begin
            if (!sb.written(nx[k], ny[k]) || (refresh && $urandom_range(3) == 0))
                write_pixel(nx[k], ny[k], rand_color());
        end
        it             = $urandom;
        it.opcode      = OP_COMPUTE;
        it.src_x       = $urandom;
        it.src_y       = $urandom;
        it.pixel_color = $urandom;
        it.dst_x       = dx;
        it.dst_y       = dy;
        send_item(it);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, val);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_sizes(input logic [CFG_W-1:0] sw, input logic [CFG_W-1:0] sh,
                             input logic [CFG_W-1:0] dw, input logic [CFG_W-1:0] dh);
        write_reg(REG_SRC_WIDTH, sw);
        write_reg(REG_SRC_HEIGHT, sh);
        write_reg(REG_DST_WIDTH, dw);
        write_reg(REG_DST_HEIGHT, dh);
    endtask

    // Drop start, wait for every pending pixel, then let the pipe drain
    task automatic settle();
        @(negedge i_clk);
        start = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Size for a register, extremes and out-of-range values included
    function automatic logic [CFG_W-1:0] pick_size(input int unsigned lo);
        int unsigned r;
        r = $urandom_range(99);
        if (r < 12) return $urandom_range(lo);
        if (r < 24) return 10'd512;
        if (r < 32) return $urandom_range(1023, 513);
        if (r < 70) return $urandom_range(12, lo);
        return $urandom_range(512, lo);
    endfunction

    initial begin
        int unsigned dw, dh, dx, dy, phase, phase_base;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_item      = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: extreme colors and coordinates at the reset sizes
        write_pixel(511, 511, 24'hFFFFFF);
        write_pixel(510, 511, 24'h000000);
        write_pixel(511, 510, 24'h000000);
        write_pixel(510, 510, 24'hFFFFFF);
        compute_at(509, 509, 1'b0);
        compute_at(511, 511, 1'b0);
        compute_at(508, 508, 1'b0);
        settle();

        // Sizes below range saturate to one-pixel source, two-pixel destination
        set_sizes('0, '0, '0, '0);
        compute_at(0, 0, 1'b0);
        compute_at(511, 511, 1'b0);
        settle();

        // Sizes above range saturate to the maximum
        set_sizes('1, '1, '1, '1);
        write_pixel(0, 0, 24'h000000);
        compute_at(511, 0, 1'b0);
        compute_at(0, 511, 1'b0);
        compute_at(255, 256, 1'b0);
        settle();

        // Random phases: mostly well-formed compute sequences, some stray writes
        phase = 0;
        while (items_sent < RANDOM_ITEMS) begin
            set_sizes(pick_size(1), pick_size(1), pick_size(2), pick_size(2));
            sb.dst_bounds(dw, dh);
            idle_on    = (phase != 3);
            phase_base = 0;
            while (phase_base < PHASE_ITEMS) begin
                if ($urandom_range(99) < 75) begin
                    dx = ($urandom_range(9) == 0) ? $urandom_range(511) : $urandom_range(dw - 1);
                    dy = ($urandom_range(9) == 0) ? $urandom_range(511) : $urandom_range(dh - 1);
                    compute_at(dx, dy, 1'b1);
                end else begin
                    write_pixel($urandom_range(511), $urandom_range(511), rand_color());
                end
                phase_base++;
            end
            phase++;
            settle();
        end

        if (sb.failures == 0 && sb.pending() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/bis_pkg.sv
rtl/core/bilinear_image_scaler_top.sv
bench/tb_top.sv
